// File: hdl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset masking.
`define XCR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication with synchronous reset masking.
`define XCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/xcr_pkg.sv
// Shared types and constants for the XMODEM checksum receiver.
package xcr_pkg;

  // Default sizing
  localparam int unsigned PAYLOAD_BYTES_DEF = 128;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  // Register map
  localparam int unsigned APB_ADDR_W         = 3;
  localparam logic        REG_NAK_INTERVAL   = 1'b0;
  localparam logic [15:0] NAK_INTERVAL_RESET = 16'd200;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  // Block number plus its complement must give this
  localparam logic [7:0] BLOCK_PAIR_SUM = 8'hFF;

  // Frame verdict codes
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_GOOD = 2'd1;
  localparam logic [1:0] VERDICT_BAD  = 2'd2;

  // Session status codes
  localparam logic [1:0] STATUS_RUNNING   = 2'd0;
  localparam logic [1:0] STATUS_COMPLETED = 2'd1;
  localparam logic [1:0] STATUS_CANCELLED = 2'd2;

  // Item class decided by the front end
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SOH,
    OP_EOT,
    OP_CAN,
    OP_OTHER
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  // Receiver phase
  typedef enum logic [2:0] {
    PH_WAIT,
    PH_IDLE,
    PH_BLK,
    PH_INV,
    PH_DATA,
    PH_SUM,
    PH_DONE,
    PH_CANCEL
  } phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [1:0] frame_verdict;
    logic [7:0] block_number;
    logic [1:0] session_status;
  } result_t;

endpackage

// File: hdl/xcr_queue.sv
// Small FIFO of classified items between the front and back ends.
module xcr_queue #(
  parameter int unsigned DEPTH = 2  // at least 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xcr_pkg::item_t push_item,
  output logic          push_ready,
  input  logic          pop,
  output logic          pop_valid,
  output xcr_pkg::item_t pop_item
);
  import xcr_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  item_t           slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = slots[rd_ptr];

  // Store incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/xcr_front.sv
// Input front end: accepts items and classifies them for the back end.
module xcr_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          mode,
  input  logic [7:0]    rx_byte,
  input  logic          q_ready,
  output logic          q_push,
  output xcr_pkg::item_t q_item
);
  import xcr_pkg::*;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  // Classify tick or control character
  always_comb begin
    q_item.data = rx_byte;
    if (mode) begin
      q_item.op = OP_TICK;
    end else if (rx_byte == CH_SOH) begin
      q_item.op = OP_SOH;
    end else if (rx_byte == CH_EOT) begin
      q_item.op = OP_EOT;
    end else if (rx_byte == CH_CAN) begin
      q_item.op = OP_CAN;
    end else begin
      q_item.op = OP_OTHER;
    end
  end

endmodule

// File: hdl/xcr_back.sv
// Protocol back end: frame state machine, checksum and output register.
module xcr_back #(
  parameter int unsigned PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [15:0]     nak_interval,
  input  logic            q_valid,
  input  xcr_pkg::item_t   q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output xcr_pkg::result_t out_res
);
  import xcr_pkg::*;

  localparam int unsigned CW = $clog2(PAYLOAD_BYTES + 1);

  phase_t       phase, phase_next;
  logic [7:0]   expected_block, expected_block_next;
  logic [7:0]   seen_block, seen_block_next;
  logic [7:0]   seen_inv, seen_inv_next;
  logic [CW-1:0] payload_count, payload_count_next;
  logic [7:0]   running_sum, running_sum_next;
  logic [15:0]  tick_count, tick_count_next;
  logic         out_valid_next;

  logic         take;
  logic         is_tick;
  logic         has_res;
  result_t      res;
  logic [16:0]  tick_sum;
  logic         tick_due;
  logic         good;
  logic [CW-1:0] cnt_inc;
  logic [CW+6:0] cnt_ext;

  assign take     = q_valid && (!out_valid || out_ready);
  assign q_pop    = take;
  assign is_tick  = (q_item.op == OP_TICK);
  assign tick_sum = {1'b0, tick_count} + 17'd1;
  assign tick_due = (tick_sum >= {1'b0, nak_interval});
  assign cnt_inc  = payload_count + 1'b1;
  assign cnt_ext  = {7'd0, payload_count};
  assign good     = (8'(seen_block + seen_inv) == BLOCK_PAIR_SUM)
                 && (q_item.data == running_sum)
                 && (seen_block == expected_block);

  // Next state
  always_comb begin
    phase_next          = phase;
    expected_block_next = expected_block;
    seen_block_next     = seen_block;
    seen_inv_next       = seen_inv;
    payload_count_next  = payload_count;
    running_sum_next    = running_sum;
    tick_count_next     = tick_count;
    case (phase)
      PH_WAIT, PH_IDLE: begin
        if (is_tick) begin
          if (phase == PH_WAIT) begin
            tick_count_next = tick_due ? 16'd0 : tick_sum[15:0];
          end
        end else begin
          case (q_item.op)
            OP_SOH: begin
              phase_next         = PH_BLK;
              payload_count_next = '0;
              running_sum_next   = '0;
            end
            OP_EOT:  phase_next = PH_DONE;
            OP_CAN:  phase_next = PH_CANCEL;
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      PH_BLK: begin
        if (!is_tick) begin
          seen_block_next = q_item.data;
          phase_next      = PH_INV;
        end
      end
      PH_INV: begin
        if (!is_tick) begin
          seen_inv_next = q_item.data;
          phase_next    = PH_DATA;
        end
      end
      PH_DATA: begin
        if (!is_tick) begin
          running_sum_next   = running_sum + q_item.data;
          payload_count_next = cnt_inc;
          if (cnt_inc >= CW'(PAYLOAD_BYTES)) begin
            phase_next = PH_SUM;
          end
        end
      end
      PH_SUM: begin
        if (!is_tick) begin
          if (good) begin
            expected_block_next = expected_block + 8'd1;
          end
          phase_next         = PH_IDLE;
          payload_count_next = '0;
          running_sum_next   = '0;
        end
      end
      default: begin
        // finished or cancelled: drop everything
      end
    endcase
  end

  // Result for the item at the queue head
  always_comb begin
    res     = '0;
    has_res = 1'b0;
    case (phase)
      PH_WAIT, PH_IDLE: begin
        if (is_tick) begin
          if (phase == PH_WAIT && tick_due) begin
            has_res      = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_byte  = CH_NAK;
          end
        end else if (q_item.op == OP_EOT) begin
          has_res            = 1'b1;
          res.tx_valid       = 1'b1;
          res.tx_byte        = CH_ACK;
          res.session_status = STATUS_COMPLETED;
        end else if (q_item.op == OP_CAN) begin
          has_res            = 1'b1;
          res.session_status = STATUS_CANCELLED;
        end
      end
      PH_DATA: begin
        if (!is_tick) begin
          has_res        = 1'b1;
          res.data_valid = 1'b1;
          res.data_byte  = q_item.data;
          res.data_index = cnt_ext[6:0];
        end
      end
      PH_SUM: begin
        if (!is_tick) begin
          has_res           = 1'b1;
          res.tx_valid      = 1'b1;
          res.block_number  = seen_block;
          res.tx_byte       = good ? CH_ACK : CH_NAK;
          res.frame_verdict = good ? VERDICT_GOOD : VERDICT_BAD;
        end
      end
      default: begin
        // no result
      end
    endcase
  end

  assign out_valid_next = take ? has_res : (out_valid && !out_ready);

  // Update protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      expected_block <= 8'd1;
      seen_block     <= '0;
      seen_inv       <= '0;
      payload_count  <= '0;
      running_sum    <= '0;
      tick_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        phase          <= phase_next;
        expected_block <= expected_block_next;
        seen_block     <= seen_block_next;
        seen_inv       <= seen_inv_next;
        payload_count  <= payload_count_next;
        running_sum    <= running_sum_next;
        tick_count     <= tick_count_next;
      end
      out_valid <= out_valid_next;
    end
  end

  // Load output register
  always_ff @(posedge clk) begin
    if (take && has_res) begin
      out_res <= res;
    end
  end

endmodule

// File: hdl/xmodem_checksum_receiver.sv
// Top level of the XMODEM checksum receiver with its configuration port.
//
//   channel   handshake                 payload
//   input     in_valid / in_ready       mode, rx_byte
//   output    out_valid / out_ready     tx_valid .. session_status
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Sustains one transaction per cycle while the output is not stalled; a
// taken input passes through a queue slot into the output register.
// Latency is set by the item queue and the registered result stage.
// Synchronous reset returns to waiting for the sender, nak_interval to 200.
// A stalled output holds its register; the queue absorbs two more items,
// then in_ready drops.
module xmodem_checksum_receiver #(
  parameter int unsigned PAYLOAD_BYTES = xcr_pkg::PAYLOAD_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH   = xcr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            mode,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            tx_valid,
  output logic [7:0]                      tx_byte,
  output logic                            data_valid,
  output logic [7:0]                      data_byte,
  output logic [6:0]                      data_index,
  output logic [1:0]                      frame_verdict,
  output logic [7:0]                      block_number,
  output logic [1:0]                      session_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [xcr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import xcr_pkg::*;

  logic        [15:0] nak_interval;
  logic               cfg_write;
  logic               q_ready;
  logic               q_push;
  item_t              q_in;
  logic               q_valid;
  logic               q_pop;
  item_t              q_out;
  result_t            res;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_NAK_INTERVAL) ? {16'd0, nak_interval} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nak_interval <= NAK_INTERVAL_RESET;
    end else if (cfg_write && (paddr[2] == REG_NAK_INTERVAL)) begin
      nak_interval <= pwdata[15:0];
    end
  end

  xcr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .rx_byte  (rx_byte),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  xcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  xcr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .nak_interval (nak_interval),
    .q_valid      (q_valid),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_res      (res)
  );

  // Unpack result fields
  assign tx_valid       = res.tx_valid;
  assign tx_byte        = res.tx_byte;
  assign data_valid     = res.data_valid;
  assign data_byte      = res.data_byte;
  assign data_index     = res.data_index;
  assign frame_verdict  = res.frame_verdict;
  assign block_number   = res.block_number;
  assign session_status = res.session_status;

endmodule

// File: hdl/xcr_checker.sv
// Port-level checker for the XMODEM checksum receiver and its bind.
`include "assert_macros.svh"

module xcr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           tx_valid,
  input logic [7:0]                     tx_byte,
  input logic                           data_valid,
  input logic [7:0]                     data_byte,
  input logic [1:0]                     frame_verdict,
  input logic [1:0]                     session_status
);
  import xcr_pkg::*;

  // A stalled result keeps its response and payload
  `XCR_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(tx_byte) && $stable(data_byte)), "stalled result changed")

  // Responses are ACK or NAK only
  `XCR_ASSERT_IMP(a_tx_code, clk, rst, out_valid && tx_valid, tx_byte == CH_ACK || tx_byte == CH_NAK, "bad response byte")

  // Payload bytes carry no response and no verdict
  `XCR_ASSERT_IMP(a_data_alone, clk, rst, out_valid && data_valid, !tx_valid && frame_verdict == VERDICT_NONE, "payload mixed with verdict")

  // A good verdict is answered with ACK
  `XCR_ASSERT_IMP(a_verdict_tx, clk, rst, out_valid && frame_verdict == VERDICT_GOOD, tx_valid && tx_byte == CH_ACK, "good frame not ACKed")

  // Completion is acknowledged
  `XCR_ASSERT_IMP(a_eot_ack, clk, rst, out_valid && session_status == STATUS_COMPLETED, tx_valid && tx_byte == CH_ACK, "EOT not ACKed")

endmodule

bind xmodem_checksum_receiver xcr_checker u_xcr_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the XMODEM checksum receiver.
`timescale 1ns / 1ps

module testbench;
  import xcr_pkg::*;

  localparam int FRAME_BYTES = int'(PAYLOAD_BYTES_DEF);  // payload bytes per frame
  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_ITEMS = 150;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int SQUEEZE_SPACING = 700;
  localparam longint TIMEOUT_CYCLES = 5_000_000;
  localparam int NAK_ADDR = 4 * REG_NAK_INTERVAL;
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_CONTROL} fill_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] octet;
  } line_item_t;

  // Block ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  mode = MODE_BYTE;
  logic [7:0]            rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  tx_valid;
  logic [7:0]            tx_byte;
  logic                  data_valid;
  logic [7:0]            data_byte;
  logic [6:0]            data_index;
  logic [1:0]            frame_verdict;
  logic [7:0]            block_number;
  logic [1:0]            session_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Line traffic still to be offered and receiver replies still to arrive
  line_item_t line_q[$];
  result_t    reply_q[$];

  // Handshake bookkeeping
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   in_gap = 0;
  bit   in_burst = 1'b0;
  int   out_hold = 0;
  bit   out_burst = 1'b0;
  int   stall_draw;
  int   next_squeeze = 150;
  int   data_seen = 0;
  int   replies_checked = 0;
  int   frames_good = 0;
  int   frames_bad = 0;
  int   items_taken = 0;
  int   fail_count = 0;

  // Receiver model state
  phase_t      rx_phase = PH_WAIT;
  logic [7:0]  next_block = 8'd1;
  logic [7:0]  hdr_block = 8'd0;
  logic [7:0]  hdr_inverse = 8'd0;
  logic [15:0] frame_fill = '0;
  logic [7:0]  frame_sum = 8'd0;
  logic [15:0] tick_cnt = '0;
  logic [15:0] nak_period = NAK_INTERVAL_RESET;

  // Sender-side view used to build frames
  logic [7:0] tx_block = 8'd1;
  int         queued_items = 0;
  bit         end_by_cancel;

  xmodem_checksum_receiver #(
    .PAYLOAD_BYTES(FRAME_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .data_valid    (data_valid),
    .data_byte     (data_byte),
    .data_index    (data_index),
    .frame_verdict (frame_verdict),
    .block_number  (block_number),
    .session_status(session_status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the receiver model by one line item; returns 1 when it replies
  function automatic bit xmodem_rx_step(input logic is_tick, input logic [7:0] octet,
                                        output result_t r);
    logic [16:0] next_ticks;
    logic [7:0]  pair;
    bit          hit;
    r = '0;
    hit = 1'b0;
    if (rx_phase == PH_DONE || rx_phase == PH_CANCEL) begin
      hit = 1'b0;
    end else if (is_tick) begin
      // ticks only count while waiting for the sender
      if (rx_phase == PH_WAIT) begin
        next_ticks = {1'b0, tick_cnt} + 17'd1;
        if (next_ticks >= {1'b0, nak_period}) begin
          tick_cnt = '0;
          r.tx_valid = 1'b1;
          r.tx_byte = CH_NAK;
          hit = 1'b1;
        end else begin
          tick_cnt = next_ticks[15:0];
        end
      end
    end else begin
      case (rx_phase)
        PH_WAIT, PH_IDLE: begin
          if (octet == CH_SOH) begin
            rx_phase = PH_BLK;
            frame_fill = '0;
            frame_sum = 8'd0;
          end else if (octet == CH_EOT) begin
            rx_phase = PH_DONE;
            r.tx_valid = 1'b1;
            r.tx_byte = CH_ACK;
            r.session_status = STATUS_COMPLETED;
            hit = 1'b1;
          end else if (octet == CH_CAN) begin
            rx_phase = PH_CANCEL;
            r.session_status = STATUS_CANCELLED;
            hit = 1'b1;
          end else begin
            rx_phase = PH_IDLE;
          end
        end
        PH_BLK: begin
          hdr_block = octet;
          rx_phase = PH_INV;
        end
        PH_INV: begin
          hdr_inverse = octet;
          rx_phase = PH_DATA;
        end
        PH_DATA: begin
          r.data_valid = 1'b1;
          r.data_byte = octet;
          r.data_index = frame_fill[6:0];
          frame_sum = frame_sum + octet;
          frame_fill = frame_fill + 16'd1;
          if (frame_fill >= FRAME_BYTES) rx_phase = PH_SUM;
          hit = 1'b1;
        end
        default: begin
          // judge the frame on the checksum byte
          pair = hdr_block + hdr_inverse;
          r.tx_valid = 1'b1;
          r.block_number = hdr_block;
          if (pair == BLOCK_PAIR_SUM && octet == frame_sum && hdr_block == next_block) begin
            r.tx_byte = CH_ACK;
            r.frame_verdict = VERDICT_GOOD;
            next_block = next_block + 8'd1;
          end else begin
            r.tx_byte = CH_NAK;
            r.frame_verdict = VERDICT_BAD;
          end
          rx_phase = PH_IDLE;
          frame_fill = '0;
          frame_sum = 8'd0;
          hit = 1'b1;
        end
      endcase
    end
    return hit;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Predict the reply of every accepted line transaction
  always @(posedge clk) begin
    result_t reply;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      items_taken++;
      if (xmodem_rx_step(mode, rx_byte, reply)) reply_q.push_back(reply);
    end
  end

  // Drive line transactions with a random gap before each one
  always @(negedge clk) begin
    line_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold until accepted
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (line_q.size() != 0) begin
      item = line_q.pop_front();
      mode <= item.mode;
      rx_byte <= item.octet;
      in_valid <= 1'b1;
      in_gap <= in_burst ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 49) == 0) in_burst <= !in_burst;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    out_fire <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        $error("reply with none predicted: tx_valid %0b tx_byte 0x%0h data_valid %0b",
               tx_valid, tx_byte, data_valid);
        fail_count++;
      end else begin
        want = reply_q.pop_front();
        replies_checked++;
        if (want.data_valid) data_seen++;
        if (want.frame_verdict == VERDICT_GOOD) frames_good++;
        if (want.frame_verdict == VERDICT_BAD) frames_bad++;
        check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
        check_field("tx_byte", want.tx_byte, tx_byte);
        check_field("data_valid", 8'(want.data_valid), 8'(data_valid));
        check_field("data_byte", want.data_byte, data_byte);
        check_field("data_index", 8'(want.data_index), 8'(data_index));
        check_field("frame_verdict", 8'(want.frame_verdict), 8'(frame_verdict));
        check_field("block_number", want.block_number, block_number);
        check_field("session_status", 8'(want.session_status), 8'(session_status));
      end
    end
  end

  // Stall the reply side at random, with a long hold-off now and then
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (data_seen >= next_squeeze) begin
      out_ready <= 1'b0;
      out_hold <= SQUEEZE_CYCLES - 1;
      next_squeeze <= next_squeeze + SQUEEZE_SPACING;
    end else if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if (out_fire) begin
      stall_draw = out_burst ? 0 : $urandom_range(0, 4);
      out_ready <= (stall_draw == 0);
      out_hold <= (stall_draw == 0) ? 0 : stall_draw - 1;
      if ($urandom_range(0, 39) == 0) out_burst <= !out_burst;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    line_q.push_back('{MODE_BYTE, b});
    queued_items++;
  endtask

  task automatic push_tick(input int n);
    repeat (n) line_q.push_back('{MODE_TICK, 8'($urandom)});
  endtask

  // Queue SOH, header, payload and checksum; sum_flip corrupts the checksum
  task automatic push_frame(input logic [7:0] blk, input logic [7:0] inv,
                            input logic [7:0] sum_flip, input fill_t fill);
    logic [7:0] d;
    logic [7:0] sum;
    int         i;
    sum = 8'd0;
    push_byte(CH_SOH);
    push_byte(blk);
    push_byte(inv);
    for (i = 0; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        FILL_CONTROL: begin
          case ($urandom_range(0, 4))
            0: d = CH_SOH;
            1: d = CH_EOT;
            2: d = CH_CAN;
            3: d = CH_ACK;
            default: d = CH_NAK;
          endcase
        end
        default: d = 8'($urandom);
      endcase
      sum = sum + d;
      push_byte(d);
    end
    push_byte(sum ^ sum_flip);
  endtask

  // Wait until every transaction is taken and answered, then let the pipe empty
  task automatic drain_line();
    @(posedge clk);
    while (line_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(NAK_ADDR);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    nak_period = value[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_ADDR_W'(NAK_ADDR);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== nak_period) begin
      $error("nak_interval mismatch: expected 0x%0h, got 0x%0h", nak_period, prdata[15:0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_interval(input logic [31:0] value);
    apb_write(value);
    apb_read_check();
  endtask

  // Stimulus
  initial begin
    int         start;
    int         pick;
    int         k;
    int         n;
    logic [7:0] blk;
    logic [7:0] b;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Start NAKs while waiting: reset interval first, then sweep the register
    apb_read_check();
    push_tick(205);
    drain_line();
    set_interval(32'd1);
    push_tick(5);
    drain_line();
    // zero acts like one; upper data bits are not part of the register
    set_interval({16'($urandom), 16'h0000});
    push_tick(4);
    drain_line();
    set_interval(32'd3);
    push_tick(10);
    drain_line();
    set_interval(32'd65535);
    push_tick(30);
    drain_line();
    // count already past the new interval: next tick sends a NAK
    set_interval(32'd5);
    push_tick(8);
    drain_line();
    set_interval(32'($urandom_range(1, 65535)));
    push_tick(50);
    drain_line();
    repeat (3) begin
      set_interval(32'($urandom_range(1, 40)));
      push_tick($urandom_range(0, 100));
      drain_line();
    end

    // Leave waiting on a non-start byte; ticks and stray bytes are ignored after
    push_byte(8'h43);
    push_tick(3);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_ACK);
    push_frame(8'd1, 8'hFE, 8'h00, FILL_CONTROL);
    push_frame(8'd2, 8'hFD, 8'h00, FILL_ZERO);
    push_frame(8'd3, 8'hFD, 8'h00, FILL_RANDOM);
    push_frame(8'd3, 8'hFC, 8'h80, FILL_RANDOM);
    push_frame(8'd2, 8'hFD, 8'h00, FILL_RANDOM);
    push_frame(8'd3, 8'hFC, 8'h00, FILL_ONES);
    push_frame(8'd0, 8'hFF, 8'h00, FILL_RANDOM);
    push_frame(8'd255, 8'h00, 8'h00, FILL_RANDOM);
    tx_block = 8'd4;

    // Mostly good frames with random content, some damaged, noise between them
    start = queued_items;
    while (queued_items - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick <= 12) begin
        push_frame(tx_block, ~tx_block, 8'h00, FILL_RANDOM);
        tx_block = tx_block + 8'd1;
      end else if (pick == 13) begin
        push_frame(tx_block, ~tx_block ^ 8'($urandom_range(1, 255)), 8'h00, FILL_RANDOM);
      end else if (pick == 14) begin
        push_frame(tx_block, ~tx_block, 8'($urandom_range(1, 255)), FILL_RANDOM);
      end else if (pick == 15) begin
        blk = tx_block + 8'($urandom_range(1, 255));
        push_frame(blk, ~blk, 8'h00, FILL_RANDOM);
      end else if (pick == 16) begin
        // garbled frame padded with zeros so the stream realigns
        push_byte(CH_SOH);
        k = $urandom_range(0, FRAME_BYTES + 3);
        repeat (k) push_byte(8'($urandom));
        repeat (FRAME_BYTES + 3 - k) push_byte(8'h00);
      end else begin
        push_frame(tx_block, ~tx_block, 8'h00, fill_t'(pick - 16));
        tx_block = tx_block + 8'd1;
      end
      n = $urandom_range(0, 2);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) begin
          push_tick(1);
        end else begin
          do b = 8'($urandom); while (b == CH_SOH || b == CH_EOT || b == CH_CAN);
          line_q.push_back('{MODE_BYTE, b});
        end
      end
    end

    // Close the session, then show that everything after it is dropped
    end_by_cancel = $urandom_range(0, 1);
    push_byte(end_by_cancel ? CH_CAN : CH_EOT);
    push_tick(5);
    push_byte(CH_SOH);
    push_byte(8'd1);
    push_byte(CH_EOT);
    push_byte(CH_CAN);

    drain_line();
    repeat (12) @(posedge clk);
    $display("Checked %0d replies for %0d line transactions: %0d frames committed, %0d discarded.",
             replies_checked, items_taken, frames_good, frames_bad);
    $display("Start NAK interval swept from 0 to 65535; session closed by %s.",
             end_by_cancel ? "CAN" : "EOT");
    if (fail_count == 0) begin
      $display("PASS xmodem_checksum_receiver");
    end else begin
      $display("FAIL xmodem_checksum_receiver");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL xmodem_checksum_receiver");
    $finish;
  end

endmodule
